[sv/rfr_pkg.sv]
// shared types and constants for the radio frame receiver
package rfr_pkg;

  // input op codes
  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_STAGE   = 2'd1;
  localparam logic [1:0] OP_SEND    = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  // command codes carried through the queue
  localparam logic [1:0] CMD_RX    = 2'd0;
  localparam logic [1:0] CMD_STAGE = 2'd1;
  localparam logic [1:0] CMD_SEND  = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_OUT     = 2'd0;
  localparam logic [1:0] KIND_RX      = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DUP_FILTER   = 2'd0;
  localparam logic [1:0] REG_TOTAL_LIMIT  = 2'd1;
  localparam logic [1:0] REG_RESEND_LIMIT = 2'd2;

  localparam logic [15:0] TOTAL_LIMIT_RESET  = 16'd6100;
  localparam logic [15:0] RESEND_LIMIT_RESET = 16'd2000;

  localparam logic [7:0] START_CHAR = 8'h61;
  localparam int TIMER_W = 17;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] code;
    logic [7:0] value;
    logic [3:0] index;
    logic       retries;
  } cmd_t;

  typedef struct packed {
    logic        dup_filter_on;
    logic [15:0] total_limit_ms;
    logic [15:0] resend_limit_ms;
  } cfg_t;

endpackage

[sv/rf_frame_receiver_with_resend.sv]
// top level of the radio frame receiver with resend timer
// Radio frame receiver with resend. Items enter on the in_valid/in_stall channel with an op:
// received byte, stage outgoing byte, send, or one-millisecond tick. The front stage
// registers each item as a command (stage writes at an index of FRAME_LEN or more are
// dropped there) and pushes it into a 4-entry command queue, so the input keeps taking
// items while a run of results is still going out, until the queue fills. The back end
// pops one command at a time. Byte, stage and quiet tick commands are done in the idle
// state. A byte that completes a frame adds a compare state, then the accepted frame goes
// out as FRAME_LEN kind-1 transfers, one per cycle from the output register when not
// stalled, with ack set when it matched the outgoing message. A send, or a tick that hits
// the resend limit, emits FRAME_LEN kind-0 transfers; a tick past the total limit emits a
// single kind-2 transfer. last marks the final transfer of each run. The configuration
// port (cfg_we, cfg_index, cfg_data) writes dup_filter_on (0), total_limit_ms (1) and
// resend_limit_ms (2); other indexes are ignored, and writes are meant to happen only
// while the block is idle.
module rf_frame_receiver_with_resend import rfr_pkg::*; #(
  parameter int FRAME_LEN = 12
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  byte_value,
  input  logic [3:0]  byte_index,
  input  logic        with_retries,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data,
  output logic        ack,
  output logic        last
);

  cfg_t cfg;
  logic front_valid;
  cmd_t front_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dup_filter_on   <= 1'b0;
      cfg.total_limit_ms  <= TOTAL_LIMIT_RESET;
      cfg.resend_limit_ms <= RESEND_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DUP_FILTER:   cfg.dup_filter_on   <= cfg_data[0];
        REG_TOTAL_LIMIT:  cfg.total_limit_ms  <= cfg_data;
        REG_RESEND_LIMIT: cfg.resend_limit_ms <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // front: accept and classify
  rfr_front #(.FRAME_LEN(FRAME_LEN)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .byte_value   (byte_value),
    .byte_index   (byte_index),
    .with_retries (with_retries),
    .cmd_valid    (front_valid),
    .cmd          (front_cmd),
    .q_full       (q_full)
  );

  // command queue decouples front and back
  rfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_valid),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // back: frame state, timers, result sequencer
  rfr_back #(.FRAME_LEN(FRAME_LEN)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .data      (data),
    .ack       (ack),
    .last      (last)
  );

endmodule

[sv/rfr_front.sv]
// input stage: takes items and turns them into queued commands
module rfr_front import rfr_pkg::*; #(
  parameter int FRAME_LEN = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] byte_value,
  input  logic [3:0] byte_index,
  input  logic       with_retries,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       q_full
);

  logic       push;
  logic       accept;
  logic       keep;
  logic [1:0] code;

  always_comb begin
    push     = cmd_valid && !q_full;
    in_stall = cmd_valid && q_full;
    accept   = in_valid && !in_stall;
    // out-of-range stage writes are dropped here
    keep     = (op != OP_STAGE) || (32'(byte_index) < FRAME_LEN);
    unique case (op)
      OP_RX_BYTE: code = CMD_RX;
      OP_STAGE:   code = CMD_STAGE;
      OP_SEND:    code = CMD_SEND;
      OP_TICK:    code = CMD_TICK;
      default:    code = CMD_TICK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (accept && keep) begin
        cmd_valid <= 1'b1;
      end else if (push) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      cmd.code    <= code;
      cmd.value   <= byte_value;
      cmd.index   <= byte_index;
      cmd.retries <= with_retries;
    end
  end

endmodule

[sv/rfr_queue.sv]
// short command fifo between front and back
module rfr_queue import rfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int PTRW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entries [QUEUE_DEPTH];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  always_comb begin
    full       = (count == CNTW'(QUEUE_DEPTH));
    head_valid = (count != '0);
    head       = entries[rd_ptr];
    do_push    = push && !full;
    do_pop     = pop && head_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[sv/rfr_back.sv]
// execution side: frame assembly, timers and the result sequencer
module rfr_back import rfr_pkg::*; #(
  parameter int FRAME_LEN = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] data,
  output logic       ack,
  output logic       last
);

  localparam int IDXW = $clog2(FRAME_LEN);
  localparam int CW   = $clog2(FRAME_LEN + 2);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]         state;
  logic [CW-1:0]      frame_count;
  logic [7:0]         incoming [FRAME_LEN];
  logic [7:0]         previous [FRAME_LEN];
  logic [7:0]         outgoing [FRAME_LEN];
  logic [7:0]         staged   [FRAME_LEN];
  logic               timers_active;
  logic [TIMER_W-1:0] since_start;
  logic [TIMER_W-1:0] since_send;
  logic [1:0]         emit_kind;
  logic               emit_ack;
  logic [IDXW-1:0]    emit_idx;

  logic [CW-1:0]      c0;
  logic [CW-1:0]      count_next;
  logic [TIMER_W-1:0] start_inc;
  logic [TIMER_W-1:0] send_inc;
  logic               diff_prev;
  logic               diff_out;
  logic               id_match;
  logic               load;
  logic               item_last;
  logic [7:0]         item_data;

  always_comb begin
    cmd_pop    = (state == ST_IDLE) && cmd_valid;
    c0         = (cmd.value == START_CHAR) ? '0 : frame_count;
    count_next = (c0 <= CW'(FRAME_LEN)) ? c0 + 1'b1 : c0;
    start_inc  = (&since_start) ? since_start : since_start + 1'b1;
    send_inc   = (&since_send) ? since_send : since_send + 1'b1;
    diff_prev  = 1'b0;
    diff_out   = 1'b0;
    for (int i = 0; i < FRAME_LEN; i++) begin
      diff_prev = diff_prev | (incoming[i] != previous[i]);
      diff_out  = diff_out | (incoming[i] != outgoing[i]);
    end
    id_match  = (incoming[1] == outgoing[1]) && (incoming[2] == outgoing[2]);
    load      = (state == ST_EMIT) && (!out_valid || !out_stall);
    item_last = (emit_kind == KIND_TIMEOUT) || (emit_idx == IDXW'(FRAME_LEN - 1));
    unique case (emit_kind)
      KIND_RX:  item_data = incoming[emit_idx];
      KIND_OUT: item_data = outgoing[emit_idx];
      default:  item_data = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frame_count   <= '0;
      incoming      <= '{default: '0};
      previous      <= '{default: '0};
      outgoing      <= '{default: '0};
      staged        <= '{default: '0};
      timers_active <= 1'b0;
      since_start   <= '0;
      since_send    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.code)
              CMD_RX: begin
                if (c0 < CW'(FRAME_LEN)) begin
                  incoming[c0[IDXW-1:0]] <= cmd.value;
                end
                frame_count <= count_next;
                if (count_next == CW'(FRAME_LEN)) begin
                  state <= ST_CHECK;
                end
              end
              CMD_STAGE: begin
                staged[IDXW'(cmd.index)] <= cmd.value;
              end
              CMD_SEND: begin
                outgoing <= staged;
                if (cmd.retries) begin
                  timers_active <= 1'b1;
                  since_start   <= '0;
                  since_send    <= '0;
                end
                emit_kind <= KIND_OUT;
                emit_ack  <= 1'b0;
                emit_idx  <= '0;
                state     <= ST_EMIT;
              end
              CMD_TICK: begin
                if (timers_active) begin
                  since_start <= start_inc;
                  if (start_inc > {1'b0, cfg.total_limit_ms}) begin
                    since_send    <= send_inc;
                    timers_active <= 1'b0;
                    emit_kind     <= KIND_TIMEOUT;
                    emit_ack      <= 1'b0;
                    emit_idx      <= '0;
                    state         <= ST_EMIT;
                  end else if (send_inc > {1'b0, cfg.resend_limit_ms}) begin
                    since_send <= '0;
                    emit_kind  <= KIND_OUT;
                    emit_ack   <= 1'b0;
                    emit_idx   <= '0;
                    state      <= ST_EMIT;
                  end else begin
                    since_send <= send_inc;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_CHECK: begin
          if (cfg.dup_filter_on && !diff_prev) begin
            state <= ST_IDLE;
          end else begin
            previous <= incoming;
            emit_ack <= !diff_out;
            if (id_match) begin
              timers_active <= 1'b0;
            end
            outgoing  <= '{default: '0};
            emit_kind <= KIND_RX;
            emit_idx  <= '0;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            if (item_last) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      kind <= emit_kind;
      data <= item_data;
      ack  <= (emit_kind == KIND_RX) ? emit_ack : 1'b0;
      last <= item_last;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    frame_count <= CW'(FRAME_LEN + 1))
    else $error("frame count past saturation");

  a_check_full: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> frame_count == CW'(FRAME_LEN))
    else $error("frame check without a complete frame");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    load && item_last |=> state == ST_IDLE && out_valid)
    else $error("run did not end after last item");

  a_timer_start: assert property (@(posedge clk) disable iff (rst)
    $rose(timers_active) |-> $past(cmd_pop && cmd.code == CMD_SEND && cmd.retries))
    else $error("timers started without a send with retries");

endmodule

[tb/tb_top.sv]
// self-checking testbench for the radio frame receiver with resend timer
module tb_top import rfr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN = 12;
  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 9;
  // non-result commands still queued inside the block drain one per cycle
  localparam int SETTLE_CYCLES = 4 * QUEUE_DEPTH + 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int MAX_REPORTS = 10;
  // register index with no register behind it, writes must be ignored
  localparam logic [1:0] REG_NONE = 2'd3;

  // frames kept packed, byte i at [i*8 +: 8]
  typedef logic [FRAME_LEN*8-1:0] frame_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       ack;
    logic       last;
  } rf_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_DUP_FILTER;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_TICK;
  logic [7:0]  byte_value = '0;
  logic [3:0]  byte_index = '0;
  logic        with_retries = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data;
  logic        ack;
  logic        last;

  rf_frame_receiver_with_resend #(
    .FRAME_LEN(FRAME_LEN)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .byte_value  (byte_value),
    .byte_index  (byte_index),
    .with_retries(with_retries),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .data        (data),
    .ack         (ack),
    .last        (last)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow of the block: registers and receiver/resend state
  // ---------------------------------------------------------------------------
  cfg_t               reg_shadow;
  logic [3:0]         rx_count;     // saturates at FRAME_LEN+1 on overlong frames
  frame_t             rx_frame;
  frame_t             prev_frame;
  frame_t             out_msg;
  frame_t             staged_msg;
  logic               timers_on;
  logic [TIMER_W-1:0] since_start;
  logic [TIMER_W-1:0] since_send;

  rf_result_t due_results[$];   // results still owed by the block, oldest first
  cmd_t       tx_items[$];      // items waiting for the input driver

  int n_in_xfers = 0;
  int n_out_xfers = 0;
  int n_errors = 0;
  int n_settings = 0;
  int n_frames = 0;
  int n_acks = 0;
  int n_resends = 0;
  int n_timeouts = 0;

  // traffic knobs, written by the sequence process
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;

  // what the generator has staged, sent and received so far
  frame_t gen_staged = '0;
  frame_t gen_sent = '0;
  frame_t gen_prev_rx = '0;
  int     gen_count = 0;

  task automatic clear_shadow();
    reg_shadow.dup_filter_on   = 1'b0;
    reg_shadow.total_limit_ms  = TOTAL_LIMIT_RESET;
    reg_shadow.resend_limit_ms = RESEND_LIMIT_RESET;
    rx_count    = '0;
    rx_frame    = '0;
    prev_frame  = '0;
    out_msg     = '0;
    staged_msg  = '0;
    timers_on   = 1'b0;
    since_start = '0;
    since_send  = '0;
  endtask

  // a whole message goes out as FRAME_LEN transfers, last on the final byte
  task automatic owe_message(input logic [1:0] k, input frame_t msg, input logic a);
    rf_result_t r;
    for (int i = 0; i < FRAME_LEN; i++) begin
      r.kind = k;
      r.data = msg[i*8 +: 8];
      r.ack  = a;
      r.last = (i == FRAME_LEN - 1);
      due_results.push_back(r);
    end
  endtask

  task automatic take_rx_byte(input logic [7:0] b);
    logic matched;
    // start char always restarts, extra bytes past a full frame fall through
    if (b == START_CHAR) rx_count = '0;
    if (rx_count < FRAME_LEN) rx_frame[rx_count*8 +: 8] = b;
    if (rx_count <= FRAME_LEN) rx_count = rx_count + 4'd1;
    if (rx_count == FRAME_LEN &&
        !(reg_shadow.dup_filter_on && rx_frame == prev_frame)) begin
      prev_frame = rx_frame;
      matched = (rx_frame == out_msg);
      // reply carrying our id (bytes 1 and 2) stops the resend machinery
      if (rx_frame[15:8] == out_msg[15:8] && rx_frame[23:16] == out_msg[23:16])
        timers_on = 1'b0;
      out_msg = '0;
      owe_message(KIND_RX, rx_frame, matched);
      n_frames++;
      if (matched) n_acks++;
    end
  endtask

  task automatic count_tick();
    rf_result_t r;
    if (timers_on) begin
      if (since_start != '1) since_start = since_start + 1'b1;
      if (since_send != '1) since_send = since_send + 1'b1;
      // total timeout wins over a resend on the same tick
      if (since_start > reg_shadow.total_limit_ms) begin
        timers_on = 1'b0;
        r.kind = KIND_TIMEOUT;
        r.data = '0;
        r.ack  = 1'b0;
        r.last = 1'b1;
        due_results.push_back(r);
        n_timeouts++;
      end else if (since_send > reg_shadow.resend_limit_ms) begin
        since_send = '0;
        owe_message(KIND_OUT, out_msg, 1'b0);
        n_resends++;
      end
    end
  endtask

  // advance the shadow by one accepted input and queue what it must produce
  task automatic apply_item(input cmd_t it);
    case (it.code)
      OP_RX_BYTE: take_rx_byte(it.value);
      OP_STAGE: begin
        if (it.index < FRAME_LEN) staged_msg[it.index*8 +: 8] = it.value;
      end
      OP_SEND: begin
        out_msg = staged_msg;
        if (it.retries) begin
          timers_on   = 1'b1;
          since_start = '0;
          since_send  = '0;
        end
        owe_message(KIND_OUT, out_msg, 1'b0);
      end
      default: count_tick();
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // input driver: one item per transfer, held steady while stalled
  // ---------------------------------------------------------------------------
  cmd_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_item(cmd_t'({op, byte_value, byte_index, with_retries}));
        n_in_xfers++;
      end
      // slot is free when nothing is offered or the offer just went through
      if (!in_valid || !in_stall) begin
        if (tx_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item    = tx_items.pop_front();
          in_valid     <= 1'b1;
          op           <= next_item.code;
          byte_value   <= next_item.value;
          byte_index   <= next_item.index;
          with_retries <= next_item.retries;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall: random per cycle, or a long hold-off when requested
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  int hold_seen = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: each transfer against the oldest owed result
  // ---------------------------------------------------------------------------
  rf_result_t got_result;
  rf_result_t want_result;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_out_xfers++;
      got_result = {kind, data, ack, last};
      if (due_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: result with nothing owed: kind %0d data %02h ack %0b last %0b",
                   $realtime, kind, data, ack, last);
      end else begin
        want_result = due_results.pop_front();
        if (got_result !== want_result) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: result %0d mismatch: want kind %0d data %02h ack %0b last %0b, %s",
                     $realtime, n_out_xfers, want_result.kind, want_result.data,
                     want_result.ack, want_result.last,
                     $sformatf("got kind %0d data %02h ack %0b last %0b",
                               kind, data, ack, last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no transfer on either channel
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results still owed",
               $realtime, quiet_cycles, due_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic [1:0] o, input logic [7:0] v,
                            input logic [3:0] x, input logic r);
    cmd_t c;
    c.code    = o;
    c.value   = v;
    c.index   = x;
    c.retries = r;
    tx_items.push_back(c);
    gen_count++;
    if (o == OP_STAGE && x < FRAME_LEN) gen_staged[x*8 +: 8] = v;
    if (o == OP_SEND) gen_sent = gen_staged;
  endtask

  // any byte except the start char, so a frame body does not restart itself
  function automatic logic [7:0] body_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if (v == START_CHAR) v = ~v;
    return v;
  endfunction

  function automatic frame_t fresh_frame();
    frame_t f;
    f[7:0] = START_CHAR;
    for (int i = 1; i < FRAME_LEN; i++) f[i*8 +: 8] = body_byte();
    return f;
  endfunction

  // fields that the op does not use get random values
  task automatic queue_frame(input frame_t f);
    for (int i = 0; i < FRAME_LEN; i++)
      queue_item(OP_RX_BYTE, f[i*8 +: 8], 4'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)));
    gen_prev_rx = f;
  endtask

  task automatic queue_message(input frame_t f);
    for (int i = 0; i < FRAME_LEN; i++)
      queue_item(OP_STAGE, f[i*8 +: 8], 4'(i), 1'($urandom_range(0, 1)));
    // now and then a write past the end, which must leave the message alone
    if ($urandom_range(0, 3) == 0)
      queue_item(OP_STAGE, 8'($urandom_range(0, 255)),
                 4'($urandom_range(FRAME_LEN, 15)), 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_scenario();
    frame_t f;
    int     pick;
    int     n;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      // new outgoing message, mostly sent right away with retries
      queue_message(fresh_frame());
      if ($urandom_range(0, 3) != 0)
        queue_item(OP_SEND, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                   $urandom_range(0, 4) != 0);
    end else if (pick < 52) begin
      // incoming frame: echo of our message, reply with our id,
      // repeat of the last frame, or something unrelated
      n = $urandom_range(0, 3);
      case (n)
        0: f = gen_sent;
        1: begin
          f = fresh_frame();
          f[23:8] = gen_sent[23:8];
        end
        2: f = gen_prev_rx;
        default: f = fresh_frame();
      endcase
      queue_frame(f);
    end else if (pick < 76) begin
      repeat ($urandom_range(1, 6))
        queue_item(OP_TICK, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)));
    end else if (pick < 86) begin
      queue_item(OP_SEND, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)));
    end else if (pick < 93) begin
      // broken frame: cut short by the next restart, or running past the end
      f = fresh_frame();
      n = $urandom_range(1, FRAME_LEN + 3);
      for (int i = 0; i < n; i++)
        queue_item(OP_RX_BYTE, (i < FRAME_LEN) ? f[i*8 +: 8] : body_byte(),
                   4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    end else begin
      // plain noise over every field
      repeat ($urandom_range(1, 4))
        queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic fill_items(input int count);
    gen_count = 0;
    while (gen_count < count) queue_scenario();
  endtask

  // sender holds back until the block has delivered everything owed
  task automatic wait_drained();
    while (tx_items.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  // register writes only while idle, after quiet commands have left the block
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DUP_FILTER:   reg_shadow.dup_filter_on = v[0];
      REG_TOTAL_LIMIT:  reg_shadow.total_limit_ms = v;
      REG_RESEND_LIMIT: reg_shadow.resend_limit_ms = v;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic dup, input logic [15:0] total,
                          input logic [15:0] resend);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    // upper data bits of the one-bit register are don't-care
    write_reg(REG_DUP_FILTER, {15'($urandom_range(0, 32767)), dup});
    write_reg(REG_TOTAL_LIMIT, total);
    write_reg(REG_RESEND_LIMIT, resend);
    n_settings++;
  endtask

  task automatic set_traffic(input int sender_pct, input int receiver_pct);
    @(posedge clk);
    send_idle_pct <= sender_pct;
    stall_pct     <= receiver_pct;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  frame_t dir_msg;

  initial begin
    clear_shadow();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: tick with timers stopped, stage writes out of range and at
    // both ends, send without retries, an exact echo that must come back
    // acked, one byte past a complete frame, then send with retries and tick
    dir_msg = '0;
    dir_msg[7:0]   = START_CHAR;
    dir_msg[23:16] = 8'h80;
    dir_msg[95:88] = 8'hFF;
    queue_item(OP_TICK, 8'h00, 4'd0, 1'b1);
    queue_item(OP_STAGE, 8'hAB, 4'd15, 1'b0);
    queue_item(OP_STAGE, 8'h55, 4'(FRAME_LEN), 1'b1);
    queue_item(OP_STAGE, START_CHAR, 4'd0, 1'b0);
    queue_item(OP_STAGE, 8'h80, 4'd2, 1'b0);
    queue_item(OP_STAGE, 8'hFF, 4'(FRAME_LEN - 1), 1'b1);
    queue_item(OP_SEND, 8'hFF, 4'd15, 1'b0);
    queue_frame(dir_msg);
    queue_item(OP_RX_BYTE, 8'h7F, 4'd0, 1'b0);
    queue_item(OP_SEND, 8'h00, 4'd0, 1'b1);
    queue_item(OP_TICK, 8'hFF, 4'd15, 1'b0);

    // short timers, no idling; mid-phase the sender waits for every result
    set_regs(1'b0, 16'd12, 16'd3);
    set_traffic(0, 0);
    fill_items(ITEMS_PER_PHASE / 2);
    wait_drained();
    fill_items(ITEMS_PER_PHASE / 2);

    // duplicate filter on, resend on every tick, total never reached
    set_regs(1'b1, 16'hFFFF, 16'h0000);
    write_reg(REG_NONE, 16'($urandom_range(0, 65535)));
    set_traffic(52, 0);
    fill_items(ITEMS_PER_PHASE);

    // every running tick times out at once; receiver holds off for a long
    // stretch first so the block backs up into its input
    set_regs(1'b1, 16'h0000, 16'hFFFF);
    set_traffic(0, 52);
    @(posedge clk);
    hold_len <= HOLD_CYCLES;
    hold_seq <= hold_seq + 1;
    queue_item(OP_SEND, 8'h00, 4'd0, 1'b1);
    fill_items(ITEMS_PER_PHASE);

    // mid-range timers with both sides idling a little
    set_regs(1'b0, 16'd20, 16'd2);
    write_reg(REG_NONE, 16'hFFFF);
    set_traffic(8, 8);
    fill_items(ITEMS_PER_PHASE);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run: %0d input transfers, %0d result transfers, %0d register settings",
             n_in_xfers, n_out_xfers, n_settings);
    $display("run: %0d frames accepted (%0d acked), %0d resends, %0d timeouts, %0d errors",
             n_frames, n_acks, n_resends, n_timeouts, n_errors);
    if (n_errors == 0 && due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
